[rtl/ptb_pkg.sv]
// Package for the periodic timer bank: request, response and entry types,
// command codes, controller states and default sizes.
// Depends on nothing; every other file of the block imports it.
package ptb_pkg;

  // Fixed field widths of the request and response.
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned LIMIT_W = 7;

  // Default number of timer handles and reset value of the list limit.
  localparam int unsigned       TIMER_HANDLES_DEF = 64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 7'd50;

  // Command codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd5;

  // One command request.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    timer_id;
    logic [COUNT_W-1:0] start_count;
    logic [COUNT_W-1:0] reload_period;
  } ptb_req_t;

  // One response.
  typedef struct packed {
    logic status;
    logic expired;
  } ptb_rsp_t;

  // One timer as it is held in the state memory.
  typedef struct packed {
    logic               listed;
    logic               expired;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] period;
  } ptb_entry_t;

  // Operation handed from the controller to the entry update logic.
  typedef struct packed {
    logic              tick;
    logic              hit;
    logic              full;
    logic [KIND_W-1:0] kind;
  } ptb_op_t;

  // Outcome of updating one entry.
  typedef struct packed {
    logic       wr;
    ptb_entry_t entry;
    logic       status;
    logic       expired;
    logic       cnt_inc;
    logic       cnt_dec;
  } ptb_upd_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_TICK_END,
    ST_DONE
  } ptb_state_t;

endpackage

[rtl/ptb_ram.sv]
// Simple dual-port synchronous RAM holding the timer entries.
// One write port and one read port with registered read data; uses ptb_pkg.
module ptb_ram #(
  parameter int unsigned DEPTH = ptb_pkg::TIMER_HANDLES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  ptb_pkg::ptb_entry_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output ptb_pkg::ptb_entry_t rdata
);
  import ptb_pkg::*;

  ptb_entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ptb_update.sv]
// Read-modify-write logic for one timer entry: applies a command or one tick.
// Uses the entry, operation and result types of ptb_pkg.
module ptb_update (
  input  ptb_pkg::ptb_op_t                    op,
  input  ptb_pkg::ptb_entry_t                 cur,
  input  logic [ptb_pkg::COUNT_W-1:0]         start_count,
  input  logic [ptb_pkg::COUNT_W-1:0]         reload_period,
  output ptb_pkg::ptb_upd_t                   upd
);
  import ptb_pkg::*;

  logic [COUNT_W-1:0] dec;
  ptb_entry_t         loaded;

  // Count after one tick, and the entry as an add or a set leaves it.
  assign dec = cur.count - COUNT_W'(1);

  always_comb begin
    loaded         = cur;
    loaded.count   = start_count;
    loaded.period  = reload_period;
    loaded.expired = (start_count == '0);
  end

  // Apply the operation.
  always_comb begin
    upd       = '0;
    upd.entry = cur;
    if (op.tick) begin
      // A listed timer with a nonzero count steps down and may expire and reload.
      if (cur.listed && cur.count != '0) begin
        upd.wr          = 1'b1;
        upd.entry.count = dec;
        if (dec == '0) begin
          upd.entry.expired = 1'b1;
          if (cur.period != '0) begin
            upd.entry.count = cur.period;
          end
        end
      end
    end else if (op.hit) begin
      case (op.kind)
        KIND_ADD: begin
          if (cur.listed) begin
            upd.wr    = 1'b1;
            upd.entry = loaded;
          end else if (op.full) begin
            upd.status = 1'b1;
          end else begin
            upd.wr           = 1'b1;
            upd.entry        = loaded;
            upd.entry.listed = 1'b1;
            upd.cnt_inc      = 1'b1;
          end
        end
        KIND_DELETE: begin
          if (cur.listed) begin
            upd.wr           = 1'b1;
            upd.entry.listed = 1'b0;
            upd.cnt_dec      = 1'b1;
          end
        end
        KIND_SET: begin
          upd.wr    = 1'b1;
          upd.entry = loaded;
        end
        KIND_STOP: begin
          upd.wr            = 1'b1;
          upd.entry.count   = '0;
          upd.entry.period  = '0;
          upd.entry.expired = 1'b0;
        end
        KIND_QUERY: begin
          upd.expired = cur.expired;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/periodic_timer_bank_unit.sv]
// Periodic timer bank: a bank of handle-addressed timers kept in one RAM.
// Uses ptb_pkg, ptb_ram and ptb_update.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready, cmd) takes one command request at a
//   time: add, delete, set, stop, query or tick. rsp channel (rsp_valid/
//   rsp_ready, rsp) returns exactly one response per request.
//   cfg channel (cfg_valid/cfg_ready, cfg_data) writes the active list limit;
//   it is always ready and should be written while no request is in flight.
// Sequencing:
//   A command other than tick issues its RAM read at the edge that accepts it;
//   in ST_EXEC, once the response register is free, it writes the entry back
//   and loads the response, then returns to ST_IDLE for the next request.
//   A tick walks every entry through the RAM, one read-modify-write a cycle,
//   through ST_TICK and ST_TICK_END; its response is loaded in ST_DONE once
//   the response register is free.
// Reset:
//   Synchronous reset starts a clearing pass that writes every entry to zero
//   in turn; cmd_ready stays low until it is done.
// Stalls:
//   The response sits in an output register; while the receiver holds off,
//   the finished request waits there and no further request is completed.
module periodic_timer_bank_unit #(
  parameter int unsigned TIMER_HANDLES = ptb_pkg::TIMER_HANDLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  ptb_pkg::ptb_req_t             cmd,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output ptb_pkg::ptb_rsp_t             rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptb_pkg::LIMIT_W-1:0]   cfg_data
);
  import ptb_pkg::*;

  localparam int unsigned IDX_W = $clog2(TIMER_HANDLES);
  localparam int unsigned EXT_W = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TIMER_HANDLES - 1);

  ptb_state_t        state, state_next;
  logic [IDX_W-1:0]  ptr, ptr_next;
  logic [LIMIT_W-1:0] active_limit;
  logic [LIMIT_W-1:0] active_count, active_count_next;
  ptb_req_t          cmd_q;
  logic              cmd_save;

  logic [EXT_W-1:0]  in_id_ext, q_id_ext;
  logic [IDX_W-1:0]  in_addr, q_addr;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  ptb_entry_t        ram_wdata, ram_rdata;

  ptb_op_t           op;
  ptb_upd_t          upd;

  logic              slot_free;
  logic              rsp_load;
  ptb_rsp_t          rsp_data;

  // Handle decode for the incoming and the held request.
  assign in_id_ext = EXT_W'(cmd.timer_id);
  assign q_id_ext  = EXT_W'(cmd_q.timer_id);
  assign in_addr   = in_id_ext[IDX_W-1:0];
  assign q_addr    = q_id_ext[IDX_W-1:0];

  // Operation seen by the update logic.
  always_comb begin
    op      = '0;
    op.tick = (state != ST_EXEC);
    op.hit  = (q_id_ext < EXT_W'(TIMER_HANDLES));
    op.full = (active_count >= active_limit);
    op.kind = cmd_q.kind;
  end

  ptb_ram #(
    .DEPTH (TIMER_HANDLES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptb_update u_update (
    .op            (op),
    .cur           (ram_rdata),
    .start_count   (cmd_q.start_count),
    .reload_period (cmd_q.reload_period),
    .upd           (upd)
  );

  assign slot_free = !rsp_valid || rsp_ready;
  assign cfg_ready = 1'b1;

  // Next state, RAM controls and response loading.
  always_comb begin
    state_next        = state;
    ptr_next          = ptr;
    ram_re            = 1'b0;
    ram_raddr         = ptr;
    ram_we            = 1'b0;
    ram_waddr         = ptr;
    ram_wdata         = upd.entry;
    rsp_load          = 1'b0;
    rsp_data          = '0;
    cmd_ready         = 1'b0;
    cmd_save          = 1'b0;
    active_count_next = active_count;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (ptr == LAST) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_save = 1'b1;
          if (cmd.kind == KIND_TICK) begin
            ptr_next   = '0;
            state_next = ST_TICK;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = in_addr;
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          ram_we    = upd.wr;
          ram_waddr = q_addr;
          rsp_load  = 1'b1;
          rsp_data.status  = upd.status;
          rsp_data.expired = upd.expired;
          if (upd.cnt_inc) begin
            active_count_next = active_count + LIMIT_W'(1);
          end else if (upd.cnt_dec && active_count != '0) begin
            active_count_next = active_count - LIMIT_W'(1);
          end
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        // Read the entry at ptr while writing back the one read in the previous cycle.
        ram_re    = 1'b1;
        ram_raddr = ptr;
        if (ptr != '0) begin
          ram_we    = upd.wr;
          ram_waddr = ptr - IDX_W'(1);
        end
        if (ptr == LAST) begin
          state_next = ST_TICK_END;
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      ST_TICK_END: begin
        ram_we     = upd.wr;
        ram_waddr  = ptr;
        ptr_next   = '0;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      ptr          <= '0;
      active_count <= '0;
      active_limit <= LIMIT_RESET;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      ptr          <= ptr_next;
      active_count <= active_count_next;
      if (cfg_valid) begin
        active_limit <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Held request and response payload.
  always_ff @(posedge clk) begin
    if (cmd_save) begin
      cmd_q <= cmd;
    end
    if (rsp_load) begin
      rsp <= rsp_data;
    end
  end

endmodule

[rtl/ptb_checker.sv]
// Port-level checks for the periodic timer bank, bound to the top level.
// Uses ptb_pkg and watches the request and response channels only.
module ptb_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input ptb_pkg::ptb_req_t cmd,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input ptb_pkg::ptb_rsp_t rsp
);
  import ptb_pkg::*;

  logic              req_take;
  logic              rsp_take;
  logic [1:0]        outstanding;
  logic [KIND_W-1:0] head_kind;
  logic [KIND_W-1:0] tail_kind;

  assign req_take = cmd_valid && cmd_ready;
  assign rsp_take = rsp_valid && rsp_ready;

  // Kinds of the requests still awaiting their responses, oldest at the head.
  // At most one response waits in the output register and one request waits
  // behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      head_kind   <= KIND_TICK;
      tail_kind   <= KIND_TICK;
    end else begin
      case ({req_take, rsp_take})
        2'b10: begin
          if (outstanding == 2'd0) begin
            head_kind <= cmd.kind;
          end else begin
            tail_kind <= cmd.kind;
          end
          outstanding <= outstanding + 2'd1;
        end
        2'b01: begin
          head_kind   <= tail_kind;
          outstanding <= outstanding - 2'd1;
        end
        2'b11: begin
          if (outstanding == 2'd1) begin
            head_kind <= cmd.kind;
          end else begin
            head_kind <= tail_kind;
            tail_kind <= cmd.kind;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A stalled response stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // The clearing pass keeps requests out right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !cmd_ready)
    else $error("request port ready during the clearing pass");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second request taken while one is in flight");

  // Only a refused add reports a failed status.
  a_status_from_add: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> head_kind == KIND_ADD)
    else $error("failed status on a request other than add");

  // Only a query reports an expired flag.
  a_expired_from_query: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.expired |-> head_kind == KIND_QUERY)
    else $error("expired flag on a request other than query");

endmodule

bind periodic_timer_bank_unit ptb_checker u_ptb_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
